[src/circle_polygon_vertex_generator_assert.svh]
// Assertion macros included by the file that checks its own logic.
`ifndef CIRCLE_POLYGON_VERTEX_GENERATOR_ASSERT_SVH
`define CIRCLE_POLYGON_VERTEX_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPVG_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPVG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/cpvg_pkg.sv]
package cpvg_pkg;

	// Field widths.
	localparam int RADIUS_W = 24;
	localparam int COORD_W  = 25;
	localparam int IDX_W    = 6;
	localparam int SLICE_W  = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;

	// Fixed-point format of coordinates and of the rotation coefficients.
	localparam int COORD_FRAC_BITS = 8;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 30;

	// Slice count limits.
	localparam int MAX_SLICES = 64;
	localparam int ROM_LIMIT  = 64;
	localparam int SLICE_CAP  = (MAX_SLICES < ROM_LIMIT) ? MAX_SLICES : ROM_LIMIT;
	localparam int MIN_SLICES = 3;
	localparam int MIN_AUTO   = 6;

	localparam logic [COORD_W-1:0] COORD_MAX = 25'd16777215;

	// Two pi in Q32 for the circumference estimate, and in Q60 for the table build.
	localparam int TP_W = 35;
	localparam logic [TP_W-1:0] TWO_PI_Q32 = 35'h6487ED511;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_COUNT   = 1'b0,
		REG_AUTO_SLICES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_ROM,
		ST_FIRST,
		ST_MUL,
		ST_NEXT
	} state_t;

	typedef struct packed {
		logic accept;
		logic size;
		logic rom;
		logic first;
		logic mult;
		logic next;
	} cpvg_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_vertex;
	} cpvg_status_t;

	// The functions below run only while the coefficient table is elaborated.
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [31:0] to_q30(input logic [63:0] pos, input logic [63:0] neg);
		logic [63:0] mag;
		if (pos >= neg) begin
			mag = (pos - neg + 64'h20000000) >> 30;
			return mag[31:0];
		end
		mag = (neg - pos + 64'h20000000) >> 30;
		return 32'(-mag[31:0]);
	endfunction

	// Returns {sin(2*pi/n), cos(2*pi/n)} in Q2.30 from a Taylor series in Q60.
	function automatic logic [63:0] sincos_q30(input int n);
		logic [63:0] x, x2, st, sp, sn, ct, cp, cn, nn, d;
		if (n < MIN_SLICES)
			return 64'd0;
		nn = 64'(n);
		x  = udiv64(TWO_PI_Q60 + (nn >> 1), nn);
		x2 = mul_q60(x, x);
		st = x;
		sp = x;
		sn = '0;
		ct = ONE_Q60;
		cp = ONE_Q60;
		cn = '0;
		for (int k = 1; k <= 20; k++) begin
			d  = 64'((2 * k) * (2 * k + 1));
			st = udiv64(mul_q60(st, x2), d);
			d  = 64'((2 * k - 1) * (2 * k));
			ct = udiv64(mul_q60(ct, x2), d);
			if (k % 2 == 1) begin
				sn = sn + st;
				cn = cn + ct;
			end else begin
				sp = sp + st;
				cp = cp + ct;
			end
		end
		return {to_q30(sp, sn), to_q30(cp, cn)};
	endfunction

endpackage

[src/cpvg_ifs.sv]
interface cpvg_circle_if;
	import cpvg_pkg::*;
	logic                valid;
	logic                ready;
	logic [RADIUS_W-1:0] radius;
	modport source (output valid, output radius, input ready);
	modport sink (input valid, input radius, output ready);
endinterface

interface cpvg_vertex_if;
	import cpvg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [IDX_W-1:0]          vertex_index;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic [SLICE_W-1:0]        slice_count;
	logic                      last;
	modport source (output valid, output vertex_index, output coord_x, output coord_y,
		output slice_count, output last, input ready);
	modport sink (input valid, input vertex_index, input coord_x, input coord_y,
		input slice_count, input last, output ready);
endinterface

interface cpvg_cfg_if;
	import cpvg_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/cpvg_ctrl.sv]
module cpvg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cpvg_pkg::cpvg_status_t status,
	output cpvg_pkg::cpvg_cmd_t    cmd
);
	import cpvg_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = ST_SIZE;
				end
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_nx = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom  = 1'b1;
				state_nx = ST_FIRST;
			end
			ST_FIRST: begin
				if (status.out_free) begin
					cmd.first = 1'b1;
					state_nx  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mult = 1'b1;
				state_nx = ST_NEXT;
			end
			ST_NEXT: begin
				if (status.out_free) begin
					cmd.next = 1'b1;
					state_nx = status.last_vertex ? ST_IDLE : ST_MUL;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

[src/cpvg_datapath.sv]
module cpvg_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpvg_pkg::cpvg_cmd_t                 cmd,
	output cpvg_pkg::cpvg_status_t              status,
	input  logic                                cfg_we,
	input  logic [cpvg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cpvg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [cpvg_pkg::RADIUS_W-1:0]       radius,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cpvg_pkg::IDX_W-1:0]          out_index,
	output logic signed [cpvg_pkg::COORD_W-1:0] out_x,
	output logic signed [cpvg_pkg::COORD_W-1:0] out_y,
	output logic [cpvg_pkg::SLICE_W-1:0]        out_slices,
	output logic                                out_last
);
	import cpvg_pkg::*;

	localparam int PROD_W    = RADIUS_W + TP_W;
	localparam int EST_SHIFT = 32 + COORD_FRAC_BITS;
	localparam int QW        = PROD_W + 1 - EST_SHIFT;
	localparam logic [PROD_W:0] EST_BIAS = (PROD_W + 1)'(5) << (EST_SHIFT - 1);
	// Quotients of five at or above this clamp exceed every slice count.
	localparam int EST_CLAMP_Q = 640;
	localparam int RECIP_W     = 10;
	localparam int RECIP_5     = 205;
	localparam int MUL_W = COORD_W + COEF_W;
	localparam int SUM_W = MUL_W + 1;
	localparam int RND_W = SUM_W - COEF_FRAC;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(COORD_MAX);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI;

	// Coefficient table, built at elaboration.
	logic signed [COEF_W-1:0] rom_sin [0:ROM_LIMIT];
	logic signed [COEF_W-1:0] rom_cos [0:ROM_LIMIT];

	for (genvar g = 0; g <= ROM_LIMIT; g++) begin : g_rom
		localparam logic [63:0] SC = sincos_q30(g);
		assign rom_sin[g] = SC[63:32];
		assign rom_cos[g] = SC[31:0];
	end

	logic [SLICE_W-1:0]        max_count_q;
	logic                      auto_slices_q;
	logic [RADIUS_W-1:0]       radius_q;
	logic [PROD_W-1:0]         prod_q;
	logic [SLICE_W-1:0]        slices_q;
	logic signed [COEF_W-1:0]  sin_q;
	logic signed [COEF_W-1:0]  cos_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [MUL_W-1:0]   p_xc_q;
	logic signed [MUL_W-1:0]   p_ys_q;
	logic signed [MUL_W-1:0]   p_yc_q;
	logic signed [MUL_W-1:0]   p_xs_q;
	logic                      out_valid_q;
	logic [IDX_W-1:0]          out_index_q;
	logic signed [COORD_W-1:0] out_x_q;
	logic signed [COORD_W-1:0] out_y_q;
	logic [SLICE_W-1:0]        out_slices_q;
	logic                      out_last_q;

	logic [PROD_W:0]           est_sum;
	logic [QW-1:0]             est_quo;
	logic [2*RECIP_W-3:0]      est_mul;
	logic [SLICE_W-1:0]        est;
	logic [SLICE_W-1:0]        slices_nx;
	logic signed [SUM_W-1:0]   sum_x;
	logic signed [SUM_W-1:0]   sum_y;
	logic signed [RND_W-1:0]   rnd_x;
	logic signed [RND_W-1:0]   rnd_y;
	logic signed [COORD_W-1:0] nx;
	logic signed [COORD_W-1:0] ny;
	logic [IDX_W-1:0]          idx_inc;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
		if (v > SAT_HI)
			return COORD_W'(SAT_HI);
		if (v < SAT_LO)
			return COORD_W'(SAT_LO);
		return COORD_W'(v);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q   <= SLICE_W'(64);
			auto_slices_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_COUNT:   max_count_q   <= cfg_data[SLICE_W-1:0];
				REG_AUTO_SLICES: auto_slices_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Slice count: in auto mode round(2*pi*r/5), floor 6, capped by max_count, else max_count; then limited.
	always_comb begin
		est_sum = {1'b0, prod_q} + EST_BIAS;
		est_quo = est_sum[PROD_W:EST_SHIFT];
		est_mul = (2*RECIP_W-2)'(est_quo[RECIP_W-1:0]) * (2*RECIP_W-2)'(RECIP_5);
		if (est_quo >= QW'(EST_CLAMP_Q))
			est = '1;
		else
			est = est_mul[RECIP_W +: SLICE_W];
		if (est < SLICE_W'(MIN_AUTO))
			est = SLICE_W'(MIN_AUTO);
		slices_nx = max_count_q;
		if (auto_slices_q && est < slices_nx)
			slices_nx = est;
		if (slices_nx < SLICE_W'(MIN_SLICES))
			slices_nx = SLICE_W'(MIN_SLICES);
		if (slices_nx > SLICE_W'(SLICE_CAP))
			slices_nx = SLICE_W'(SLICE_CAP);
	end

	// Rotation sums, rounded to nearest with ties upward, then saturated.
	always_comb begin
		sum_x   = SUM_W'(p_xc_q) - SUM_W'(p_ys_q) + ROUND_HALF;
		sum_y   = SUM_W'(p_yc_q) + SUM_W'(p_xs_q) + ROUND_HALF;
		rnd_x   = RND_W'(sum_x >>> COEF_FRAC);
		rnd_y   = RND_W'(sum_y >>> COEF_FRAC);
		nx      = sat_coord(rnd_x);
		ny      = sat_coord(rnd_y);
		idx_inc = idx_q + IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			radius_q <= radius;
			prod_q   <= PROD_W'(radius) * PROD_W'(TWO_PI_Q32);
		end
		if (cmd.size)
			slices_q <= slices_nx;
		if (cmd.rom) begin
			sin_q <= rom_sin[slices_q];
			cos_q <= rom_cos[slices_q];
			x_q   <= COORD_W'(signed'({1'b0, radius_q}));
			y_q   <= '0;
			idx_q <= '0;
		end
		if (cmd.mult) begin
			p_xc_q <= MUL_W'(x_q) * MUL_W'(cos_q);
			p_ys_q <= MUL_W'(y_q) * MUL_W'(sin_q);
			p_yc_q <= MUL_W'(y_q) * MUL_W'(cos_q);
			p_xs_q <= MUL_W'(x_q) * MUL_W'(sin_q);
		end
		if (cmd.next) begin
			x_q   <= nx;
			y_q   <= ny;
			idx_q <= idx_inc;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.first || cmd.next) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.first) begin
			// Vertex 0 is never the last one, since a polygon has three vertices or more.
			out_index_q  <= '0;
			out_x_q      <= x_q;
			out_y_q      <= y_q;
			out_slices_q <= slices_q;
			out_last_q   <= 1'b0;
		end else if (cmd.next) begin
			out_index_q  <= idx_inc;
			out_x_q      <= nx;
			out_y_q      <= ny;
			out_slices_q <= slices_q;
			out_last_q   <= status.last_vertex;
		end
	end

	assign status.out_free    = !out_valid_q || out_ready;
	assign status.last_vertex = (SLICE_W'(idx_q) + SLICE_W'(2)) == slices_q;

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_slices = out_slices_q;
	assign out_last   = out_last_q;

endmodule

[src/circle_polygon_vertex_generator.sv]
// Circle polygon vertex generator. Each radius beat (unsigned Q16.8) produces one vertex
// beat per corner of a regular polygon centered on the origin: vertex 0 is (r, 0) and every
// later vertex is the previous, saturated vertex rotated by 2*pi/N, with sin and cos taken
// from a Q2.30 table indexed by N and each coordinate rounded to nearest and saturated to
// +-16777215. N is min(max(6, round(2*pi*r/5)), max_count) in auto mode and max_count
// otherwise, always held within 3 to 64. A radius passes through steps that form the
// circumference product, pick N, read the coefficient table and issue vertex 0; each
// further vertex then goes through a multiplier stage and a round-and-saturate stage,
// because each rotation needs the vertex before it. The next radius is taken as soon as the
// final vertex sits in the output register. Configuration beats are always taken and must
// arrive only while idle.

module circle_polygon_vertex_generator (
	input  logic          clk,
	input  logic          arst_n,
	cpvg_circle_if.sink   circle,
	cpvg_vertex_if.source vertex,
	cpvg_cfg_if.sink      cfg
);
	import cpvg_pkg::*;

	cpvg_cmd_t    cmd;
	cpvg_status_t status;

	// The configuration registers never hold off a write.
	assign cfg.ready = 1'b1;

	cpvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (circle.valid),
		.in_ready (circle.ready),
		.status   (status),
		.cmd      (cmd)
	);

	cpvg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.radius     (circle.radius),
		.out_valid  (vertex.valid),
		.out_ready  (vertex.ready),
		.out_index  (vertex.vertex_index),
		.out_x      (vertex.coord_x),
		.out_y      (vertex.coord_y),
		.out_slices (vertex.slice_count),
		.out_last   (vertex.last)
	);

	`include "circle_polygon_vertex_generator_assert.svh"

	// The last vertex of a run sits at index N - 1.
	`CPVG_ASSERT_SAME(a_last_index, clk, arst_n, vertex.valid && vertex.last, vertex.vertex_index == IDX_W'(vertex.slice_count - SLICE_W'(1)), "last vertex index does not match slice count")

	// Vertex 0 lies on the x axis.
	`CPVG_ASSERT_SAME(a_first_on_axis, clk, arst_n, vertex.valid && vertex.vertex_index == '0, vertex.coord_y == '0, "vertex 0 has nonzero y")

	// The slice count stays within the polygon limits.
	`CPVG_ASSERT_SAME(a_slice_range, clk, arst_n, vertex.valid, vertex.slice_count >= SLICE_W'(MIN_SLICES) && vertex.slice_count <= SLICE_W'(SLICE_CAP), "slice count out of range")

	// A run in progress holds off the next radius.
	`CPVG_ASSERT_NEXT(a_one_run, clk, arst_n, circle.valid && circle.ready, !circle.ready, "radius taken while a run is in progress")

endmodule

[verif/circle_polygon_vertex_generator_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the circle polygon vertex generator. Radius beats go in on the
// circle channel, and every one of them is expanded here into the list of vertex beats the
// block has to produce. Vertex beats that come back are matched, in order, against that list.
// The coefficient table is rebuilt at time zero from the same Q60 Taylor series the hardware
// table is based on, so the rotation is predicted exactly, with rounding and saturation.
module circle_polygon_vertex_generator_tb;
	import cpvg_pkg::*;

	// The bench gives up after this many cycles in which no channel moves a beat.
	localparam int NO_BEAT_LIMIT = 5000;
	// Half an LSB of the Q30 products, added before the floor shift.
	localparam longint HALF_Q30 = longint'(1) << 29;
	// Denominator of the circumference estimate: 5 units, with the Q32 and radius fractions.
	localparam logic [63:0] AUTO_DEN = 64'd5 << (32 + COORD_FRAC_BITS);

	typedef struct {
		logic [IDX_W-1:0]          index;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SLICE_W-1:0]        slices;
		logic                      last;
	} vertex_beat_t;

	logic clk;
	logic arst_n;

	cpvg_circle_if circle_ch ();
	cpvg_vertex_if vertex_ch ();
	cpvg_cfg_if    cfg_ch ();

	circle_polygon_vertex_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.circle (circle_ch),
		.vertex (vertex_ch),
		.cfg    (cfg_ch)
	);

	// Sine and cosine of 2*pi/n in Q2.30, indexed by slice count.
	longint sin_tab [0:ROM_LIMIT];
	longint cos_tab [0:ROM_LIMIT];

	// Mirror of the block's registers and of the vertex it last stored.
	logic [SLICE_W-1:0] count_reg;
	logic               auto_reg;
	longint             stored_x;
	longint             stored_y;

	// Vertex beats still owed by the block, oldest first.
	vertex_beat_t pending_vertices [$];

	int mismatches    = 0;
	int radii_sent    = 0;
	int vertices_seen = 0;
	int cfg_writes    = 0;
	int quiet_cycles  = 0;
	int stall_left    = 0;
	bit idle_on       = 1'b1;

	always #5 clk = ~clk;

	// (a * b) >> 60 for unsigned Q60 operands.
	function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = 128'(a) * 128'(b);
		return wide[123:60];
	endfunction

	// Difference of two Q60 partial sums, rounded to the nearest Q30 value.
	function automatic longint round_to_q30(input logic [63:0] pos, input logic [63:0] neg);
		if (pos >= neg)
			return longint'((pos - neg + HALF_Q30) >> 30);
		return -longint'((neg - pos + HALF_Q30) >> 30);
	endfunction

	// Twenty-one terms of the sine and cosine series are summed separately by sign, so the
	// unsigned Q60 arithmetic never goes negative until the final rounding step.
	function automatic void fill_coef_table();
		logic [63:0] ang, ang_sq, s_term, c_term, s_add, s_sub, c_add, c_sub;
		for (int n = 0; n <= ROM_LIMIT; n++) begin
			sin_tab[n] = 0;
			cos_tab[n] = 0;
		end
		for (int n = MIN_SLICES; n <= ROM_LIMIT; n++) begin
			ang    = (TWO_PI_Q60 + 64'(n / 2)) / 64'(n);
			ang_sq = q60_product(ang, ang);
			s_term = ang;
			s_add  = ang;
			s_sub  = '0;
			c_term = ONE_Q60;
			c_add  = ONE_Q60;
			c_sub  = '0;
			for (int k = 1; k <= 20; k++) begin
				s_term = q60_product(s_term, ang_sq) / 64'((2 * k) * (2 * k + 1));
				c_term = q60_product(c_term, ang_sq) / 64'((2 * k - 1) * (2 * k));
				if (k % 2 == 1) begin
					s_sub = s_sub + s_term;
					c_sub = c_sub + c_term;
				end else begin
					s_add = s_add + s_term;
					c_add = c_add + c_term;
				end
			end
			sin_tab[n] = round_to_q30(s_add, s_sub);
			cos_tab[n] = round_to_q30(c_add, c_sub);
		end
	endfunction

	// Slice count for one radius under the current register settings. In auto mode the
	// circumference estimate is floored at six and then capped by max_count; the result is
	// always held between three and the table size.
	function automatic int pick_slices(input logic [RADIUS_W-1:0] r);
		logic [63:0] est;
		int n;
		n = int'(count_reg);
		if (auto_reg) begin
			est = (64'(r) * 64'(TWO_PI_Q32) + (AUTO_DEN >> 1)) / AUTO_DEN;
			if (est < 64'(MIN_AUTO))
				est = 64'(MIN_AUTO);
			if (est < 64'(n))
				n = int'(est);
		end
		if (n < MIN_SLICES)
			n = MIN_SLICES;
		if (n > SLICE_CAP)
			n = SLICE_CAP;
		return n;
	endfunction

	function automatic longint clip_coord(input longint v);
		if (v > longint'(COORD_MAX))
			return longint'(COORD_MAX);
		if (v < -longint'(COORD_MAX))
			return -longint'(COORD_MAX);
		return v;
	endfunction

	// Expands one accepted radius into its vertex beats. Every rotation starts from the
	// saturated vertex before it, exactly as the block stores it.
	function automatic void plan_polygon(input logic [RADIUS_W-1:0] r);
		vertex_beat_t beat;
		int n;
		longint s, c, nx, ny;
		n = pick_slices(r);
		s = sin_tab[n];
		c = cos_tab[n];
		stored_x = longint'(r);
		stored_y = 0;
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				nx = clip_coord((stored_x * c - stored_y * s + HALF_Q30) >>> 30);
				ny = clip_coord((stored_y * c + stored_x * s + HALF_Q30) >>> 30);
				stored_x = nx;
				stored_y = ny;
			end
			beat.index  = IDX_W'(i);
			beat.x      = stored_x[COORD_W-1:0];
			beat.y      = stored_y[COORD_W-1:0];
			beat.slices = SLICE_W'(n);
			beat.last   = (i == n - 1);
			pending_vertices.push_back(beat);
		end
	endfunction

	// Radii are spread over the whole field, over the range where the auto slice count is
	// still below the cap, over very small circles, and over the top of the range where
	// the rotated coordinates can saturate.
	function automatic logic [RADIUS_W-1:0] random_radius();
		case ($urandom_range(0, 4))
			0, 1: return RADIUS_W'($urandom);
			2: return RADIUS_W'($urandom_range(0, 16383));
			3: return RADIUS_W'($urandom_range(0, 1500));
			default: return RADIUS_W'($urandom_range(16776000, 16777215));
		endcase
	endfunction

	// Mostly legal slice counts, with the whole 7-bit field now and then.
	function automatic logic [SLICE_W-1:0] random_count();
		if ($urandom_range(0, 3) == 0)
			return SLICE_W'($urandom_range(0, 127));
		return SLICE_W'($urandom_range(MIN_SLICES, SLICE_CAP));
	endfunction

	// Sends one radius beat. Valid stays high after the beat is taken so that the next call
	// can follow without a bubble; the caller lowers it when the stream pauses.
	task automatic send_radius(input logic [RADIUS_W-1:0] r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			circle_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		circle_ch.valid  <= 1'b1;
		circle_ch.radius <= r;
		do @(posedge clk); while (!circle_ch.ready);
		plan_polygon(r);
		radii_sent++;
	endtask

	// Stops the radius stream and waits until every owed vertex beat has come back. Every
	// radius makes at least three vertex beats and the block goes idle once the final one sits
	// in its output register, before it is taken, so an empty list means the block is idle.
	task automatic wait_idle();
		circle_ch.valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (which)
			REG_MAX_COUNT:   count_reg = value;
			REG_AUTO_SLICES: auto_reg = value[0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Both registers are written back to back while the block is idle.
	task automatic set_config(input logic [SLICE_W-1:0] count, input logic auto_mode);
		wait_idle();
		write_reg(REG_MAX_COUNT, count);
		write_reg(REG_AUTO_SLICES, CFG_DATA_W'(auto_mode));
		cfg_ch.valid <= 1'b0;
	endtask

	// Default settings after reset: zero radius, a unit LSB radius, both sides of the
	// rounding step into seven slices and into the cap of 64, the largest radius (which
	// drives the rotation into saturation) and alternating bit patterns.
	task automatic test_default_auto();
		logic [RADIUS_W-1:0] picks [$];
		picks = '{24'd0, 24'd1, 24'd1324, 24'd1325, 24'd12936, 24'd12937,
			24'hFFFFFF, 24'hAAAAAA, 24'h555555};
		foreach (picks[i])
			send_radius(picks[i]);
	endtask

	// Fixed slice counts, including the values below three that are raised to three and
	// the values above the table size that are cut down to it.
	task automatic test_fixed_count();
		logic [SLICE_W-1:0] counts [$];
		counts = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127};
		foreach (counts[i]) begin
			set_config(counts[i], 1'b0);
			send_radius(counts[i] == 7'd64 ? 24'hFFFFFF : RADIUS_W'($urandom));
		end
	endtask

	// Auto mode under a tight cap, and under a cap below the legal minimum.
	task automatic test_auto_cap();
		set_config(7'd3, 1'b1);
		send_radius(24'hFFFFFF);
		set_config(7'd7, 1'b1);
		send_radius(24'd1325);
		send_radius(24'd20000);
		set_config(7'd0, 1'b1);
		send_radius(24'd5000);
	endtask

	// Random settings per phase, random radii within each phase, with both sides stalling.
	task automatic test_random_phases(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_config(random_count(), 1'($urandom_range(0, 1)));
			repeat (per_phase)
				send_radius(random_radius());
		end
	endtask

	// Full rate on both sides with the longest polygons the block can make.
	task automatic test_full_rate(input int count);
		set_config(7'd127, 1'b0);
		idle_on = 1'b0;
		repeat (count)
			send_radius(random_radius());
	endtask

	// The sink lowers ready at random while idling is allowed.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			vertex_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			vertex_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			vertex_ch.ready <= 1'b1;
		end
	end

	// Each vertex beat is compared field by field with the oldest owed beat.
	always @(posedge clk) begin : check_vertices
		vertex_beat_t want;
		if (arst_n && vertex_ch.valid && vertex_ch.ready) begin
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				$error("vertex beat %0d arrived with no radius outstanding",
					vertex_ch.vertex_index);
				mismatches++;
			end else begin
				want = pending_vertices.pop_front();
				if (vertex_ch.vertex_index !== want.index) begin
					$error("vertex_index: expected %0d, got %0d", want.index,
						vertex_ch.vertex_index);
					mismatches++;
				end
				if (vertex_ch.coord_x !== want.x) begin
					$error("coord_x: expected %0d, got %0d", want.x, vertex_ch.coord_x);
					mismatches++;
				end
				if (vertex_ch.coord_y !== want.y) begin
					$error("coord_y: expected %0d, got %0d", want.y, vertex_ch.coord_y);
					mismatches++;
				end
				if (vertex_ch.slice_count !== want.slices) begin
					$error("slice_count: expected %0d, got %0d", want.slices,
						vertex_ch.slice_count);
					mismatches++;
				end
				if (vertex_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, vertex_ch.last);
					mismatches++;
				end
			end
		end
	end

	// A hang shows up as a long stretch without a single beat on any channel.
	always @(posedge clk) begin
		if ((circle_ch.valid && circle_ch.ready) || (vertex_ch.valid && vertex_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= NO_BEAT_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d vertex beats still owed",
				quiet_cycles, pending_vertices.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		circle_ch.valid  = 1'b0;
		circle_ch.radius = '0;
		vertex_ch.ready  = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_MAX_COUNT;
		cfg_ch.data      = '0;
		count_reg        = SLICE_W'(SLICE_CAP);
		auto_reg         = 1'b1;
		stored_x         = 0;
		stored_y         = 0;
		fill_coef_table();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_default_auto();
		test_fixed_count();
		test_auto_cap();
		test_random_phases(11, 40);
		test_full_rate(40);

		// Let any stray beat after the final vertex show up before the verdict.
		wait_idle();
		repeat (2 * SLICE_CAP + 8) @(posedge clk);

		$display("Covered %0d radii giving %0d vertex beats, with %0d register writes.",
			radii_sent, vertices_seen, cfg_writes);
		$display("Settings ranged over fixed and auto slice counts from 0 to 127.");
		if (mismatches == 0 && pending_vertices.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
